[hw/rtl/pdq_pkg.sv]
`timescale 1ns / 1ps

package pdq_pkg;

  // Operation codes carried by an input beat
  typedef enum logic [2:0] {
    KIND_PUSH_HEAD = 3'd0,
    KIND_PUSH_TAIL = 3'd1,
    KIND_POP_HEAD  = 3'd2,
    KIND_POP_TAIL  = 3'd3,
    KIND_PEEK_AT   = 3'd4,
    KIND_REMOVE_AT = 3'd5
  } pdq_kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } pdq_status_t;

  // Command broadcast along the cell chain
  typedef enum logic [1:0] {
    CMD_HOLD      = 2'd0,
    CMD_INS_HEAD  = 2'd1,
    CMD_INS_TAIL  = 2'd2,
    CMD_CLOSE_GAP = 2'd3
  } pdq_cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] data_in;
    logic [9:0]  position;
  } pdq_in_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic        found;
    logic [1:0]  status;
    logic [10:0] entry_count;
    logic        is_empty;
  } pdq_out_t;

endpackage

[hw/rtl/positional_deque_top.sv]
`timescale 1ns / 1ps

// Positional deque: an ordered store of up to DEPTH words, head at cell 0.
// Input channel in_valid / in_ready / in_data carries one operation per beat:
// push head, push tail, pop head, pop tail, peek at a position, or remove at a
// position (later entries close up toward the head).
// Result channel out_valid / out_ready / out_data returns exactly one beat per
// operation: data word, found flag, status, entry count and empty flag.
// The result is registered: it appears in the output register in the cycle
// after the input beat is accepted.
// Throughput: one operation per cycle while the output is not stalled. Every
// cell of the chain loads its next word in parallel, so even a remove in the
// middle needs no step-by-step shifting; the single output register sets the figure.
// Stall: while out_valid is high and out_ready is low the result is held and
// in_ready drops; a new beat is taken in the same cycle the held result leaves.
// Reset (rst_n low, synchronous): the store is emptied and the output register
// is invalidated. Cell contents are not cleared; an entry is always written
// before it is read.
// A push into a full store is refused with status full; a pop, peek or remove
// with nothing at that place returns status none with found low.

module positional_deque_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pdq_pkg::pdq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pdq_pkg::pdq_out_t out_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (OCC_W > 10) ? OCC_W : 10;

  // occupancy and output register
  logic [OCC_W-1:0]  occ_r;
  logic [OCC_W-1:0]  occ_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  pdq_pkg::pdq_out_t out_data_r;
  pdq_pkg::pdq_out_t out_data_nxt;

  logic fire;
  logic full;
  logic empty;
  logic pos_hit;

  pdq_pkg::pdq_cmd_t     cmd;
  logic [IDX_W-1:0]      tgt;
  logic [IDX_W-1:0]      rd_idx;
  logic [DATA_WIDTH-1:0] ins_word;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];

  // Take a new beat whenever the output register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  assign full     = (occ_r == OCC_W'(DEPTH));
  assign empty    = (occ_r == '0);
  assign pos_hit  = (CMP_W'(in_data.position) < CMP_W'(occ_r));
  assign ins_word = DATA_WIDTH'(in_data.data_in);
  assign rd_word  = cell_q[rd_idx];

  always_comb begin
    cmd           = pdq_pkg::CMD_HOLD;
    tgt           = '0;
    rd_idx        = '0;
    occ_nxt       = occ_r;
    out_data_nxt  = '0;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (in_data.kind)
      pdq_pkg::KIND_PUSH_HEAD: begin
        if (full) begin
          out_data_nxt.status = pdq_pkg::STAT_FULL;
        end else begin
          cmd     = pdq_pkg::CMD_INS_HEAD;
          occ_nxt = occ_r + 1'b1;
        end
      end
      pdq_pkg::KIND_PUSH_TAIL: begin
        if (full) begin
          out_data_nxt.status = pdq_pkg::STAT_FULL;
        end else begin
          cmd     = pdq_pkg::CMD_INS_TAIL;
          tgt     = IDX_W'(occ_r);
          occ_nxt = occ_r + 1'b1;
        end
      end
      pdq_pkg::KIND_POP_HEAD: begin
        if (empty) begin
          out_data_nxt.status = pdq_pkg::STAT_NONE;
        end else begin
          cmd                   = pdq_pkg::CMD_CLOSE_GAP;
          out_data_nxt.found    = 1'b1;
          out_data_nxt.data_out = 32'(rd_word);
          occ_nxt               = occ_r - 1'b1;
        end
      end
      pdq_pkg::KIND_POP_TAIL: begin
        // last entry simply drops off; no shift needed
        rd_idx = IDX_W'(occ_r - 1'b1);
        if (empty) begin
          out_data_nxt.status = pdq_pkg::STAT_NONE;
        end else begin
          out_data_nxt.found    = 1'b1;
          out_data_nxt.data_out = 32'(rd_word);
          occ_nxt               = occ_r - 1'b1;
        end
      end
      pdq_pkg::KIND_PEEK_AT: begin
        rd_idx = IDX_W'(in_data.position);
        if (!pos_hit) begin
          out_data_nxt.status = pdq_pkg::STAT_NONE;
        end else begin
          out_data_nxt.found    = 1'b1;
          out_data_nxt.data_out = 32'(rd_word);
        end
      end
      pdq_pkg::KIND_REMOVE_AT: begin
        rd_idx = IDX_W'(in_data.position);
        tgt    = IDX_W'(in_data.position);
        if (!pos_hit) begin
          out_data_nxt.status = pdq_pkg::STAT_NONE;
        end else begin
          cmd                   = pdq_pkg::CMD_CLOSE_GAP;
          out_data_nxt.found    = 1'b1;
          out_data_nxt.data_out = 32'(rd_word);
          occ_nxt               = occ_r - 1'b1;
        end
      end
      default: begin
        // unused codes: no operation, plain ok result
      end
    endcase

    out_data_nxt.entry_count = 11'(occ_nxt);
    out_data_nxt.is_empty    = (occ_nxt == '0);

    // Drop the command and hold the count unless a beat is really taken
    if (!fire) begin
      cmd     = pdq_pkg::CMD_HOLD;
      occ_nxt = occ_r;
    end else begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register: advance only on an accepted beat
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Chain of cells: each sees its neighbours, the last one sees itself
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w;
    logic [DATA_WIDTH-1:0] next_w;

    if (gi == 0) begin : g_first
      assign prev_w = ins_word;
    end else begin : g_mid_prev
      assign prev_w = cell_q[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_last
      assign next_w = cell_q[gi];
    end else begin : g_mid_next
      assign next_w = cell_q[gi+1];
    end

    pdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .IDX        (gi)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .tgt       (tgt),
      .ins_data  (ins_word),
      .prev_data (prev_w),
      .next_data (next_w),
      .data_q    (cell_q[gi])
    );
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.found |-> out_data_r.status == pdq_pkg::STAT_OK)
    else $error("found result with bad status");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.is_empty == (out_data_r.entry_count == 11'd0))
    else $error("empty flag disagrees with count");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fire && full && (in_data.kind == pdq_pkg::KIND_PUSH_HEAD ||
                     in_data.kind == pdq_pkg::KIND_PUSH_TAIL) |=> $stable(occ_r))
    else $error("refused push changed occupancy");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && out_data_r.entry_count == 11'(occ_r))
    else $error("result missing or count mismatch");
`endif

endmodule

[hw/rtl/pdq_cell.sv]
`timescale 1ns / 1ps

module pdq_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 4,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  pdq_pkg::pdq_cmd_t     cmd,
  input  logic [IDX_W-1:0]      tgt,
  input  logic [DATA_WIDTH-1:0] ins_data,
  input  logic [DATA_WIDTH-1:0] prev_data,
  input  logic [DATA_WIDTH-1:0] next_data,
  output logic [DATA_WIDTH-1:0] data_q
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic [IDX_W-1:0]      my_idx;

  assign my_idx = IDX_W'(IDX);

  always_comb begin
    data_nxt = data_r;
    unique case (cmd)
      pdq_pkg::CMD_HOLD:      data_nxt = data_r;
      // shift one place toward the tail
      pdq_pkg::CMD_INS_HEAD:  data_nxt = prev_data;
      pdq_pkg::CMD_INS_TAIL:  if (my_idx == tgt) data_nxt = ins_data;
      // take the neighbour's word from the gap onwards
      pdq_pkg::CMD_CLOSE_GAP: if (my_idx >= tgt) data_nxt = next_data;
      default:                data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule
